>>> sv/cmsb_pkg.sv
package cmsb_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int LEN_W      = IDX_W + 1;
  localparam int SUM_W      = 64;
  // Reduction steps done in the second modulo stage; the rest go in the first.
  localparam int MOD_SPLIT  = LEN_W / 2;

  // Everything the end-of-sequence selection needs, taken at the last word.
  typedef struct packed {
    logic [SUM_W-1:0]   total;
    logic [VALUE_W-1:0] peak_val;
    logic [IDX_W-1:0]   peak_idx;
    logic [VALUE_W-1:0] trough_val;
    logic [IDX_W-1:0]   trough_idx;
    logic [SUM_W-1:0]   hbest;
    logic [IDX_W-1:0]   hstart;
    logic [IDX_W-1:0]   hend;
    logic [SUM_W-1:0]   lbest;
    logic [IDX_W-1:0]   lstart;
    logic [IDX_W-1:0]   lend;
    logic [LEN_W-1:0]   len;
  } snap_t;

  // Two dividends reduced modulo a common length.
  typedef struct packed {
    logic [LEN_W-1:0] ds;
    logic [LEN_W-1:0] de;
    logic [LEN_W-1:0] len;
  } job_t;

  // One restoring step: take off len << k when it fits.
  function automatic logic [LEN_W-1:0] mod_step(input logic [LEN_W-1:0] d,
                                                input logic [LEN_W-1:0] len,
                                                input int k);
    logic [2*LEN_W-1:0] sh;
    logic [2*LEN_W-1:0] dw;
    sh = {{LEN_W{1'b0}}, len} << k;
    dw = {{LEN_W{1'b0}}, d};
    if (dw >= sh) begin
      return LEN_W'(dw - sh);
    end
    return d;
  endfunction

endpackage

>>> sv/cmsb_if.sv
interface cmsb_in_if;
  logic                         valid;
  logic                         ready;
  logic [cmsb_pkg::VALUE_W-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface cmsb_out_if;
  logic                       valid;
  logic                       ready;
  logic [cmsb_pkg::IDX_W-1:0] start_index;
  logic [cmsb_pkg::IDX_W-1:0] end_index;

  modport source (output valid, output start_index, output end_index, input ready);
  modport sink (input valid, input start_index, input end_index, output ready);
endinterface

>>> sv/circular_max_subarray_bounds_core.sv
// A result moves from the input register via snapshot, selection and modulo to output.
// Throughput: one word per cycle unless stalled by the output; a new sequence may start
// right after a last word. The accumulators, the end-of-sequence selection and wrap
// arithmetic, and the two-stage modulo on the indices are each registered.
// Reset: synchronous, active-low rst_n empties every stage and clears the accumulators.
module circular_max_subarray_bounds_core (
  input  logic       clk,
  input  logic       rst_n,
  cmsb_in_if.sink    in_ch,
  cmsb_out_if.source out_ch
);
  import cmsb_pkg::*;

  // Snapshot of the running state at a last word, handed to the selection.
  logic  snap_v;
  snap_t snap;
  logic  ld_s1;

  // Start/end dividends and the length they are reduced by.
  logic  job_v;
  job_t  job;
  logic  ld_s3;

  // Input register, position counter, total, peak/trough and both Kadane runs.
  // The accumulators clear themselves as the last word is folded in, so the
  // next sequence can follow with no gap.
  cmsb_acc u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .ld_s1  (ld_s1),
    .snap_v (snap_v),
    .snap   (snap)
  );

  // Hold the snapshot, then pick between peak element, linear run and wrap run.
  // The wrap run spans from just after the min run to just before it.
  cmsb_sel u_sel (
    .clk    (clk),
    .rst_n  (rst_n),
    .snap_v (snap_v),
    .snap   (snap),
    .ld_s1  (ld_s1),
    .ld_s3  (ld_s3),
    .job_v  (job_v),
    .job    (job)
  );

  // Reduce both indices modulo the sequence length and drive the result word;
  // the output register lets new words enter while a result waits.
  cmsb_mod u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .job_v  (job_v),
    .job    (job),
    .ld_s3  (ld_s3),
    .out_ch (out_ch)
  );

endmodule

>>> sv/cmsb_acc.sv
module cmsb_acc (
  input  logic            clk,
  input  logic            rst_n,
  cmsb_in_if.sink         in_ch,
  input  logic            ld_s1,
  output logic            snap_v,
  output cmsb_pkg::snap_t snap
);
  import cmsb_pkg::*;

  logic               s0_v_r;
  logic [VALUE_W-1:0] value_r;
  logic               last_r;
  logic               s0_go;

  logic               loaded_r;
  logic [IDX_W-1:0]   pos_r;
  logic [SUM_W-1:0]   total_r;
  logic [VALUE_W-1:0] peak_val_r;
  logic [IDX_W-1:0]   peak_idx_r;
  logic [VALUE_W-1:0] trough_val_r;
  logic [IDX_W-1:0]   trough_idx_r;
  logic [SUM_W-1:0]   hrun_r;
  logic [IDX_W-1:0]   hstart_r;
  logic [SUM_W-1:0]   hbest_r;
  logic [IDX_W-1:0]   hbs_r;
  logic [IDX_W-1:0]   hbe_r;
  logic [SUM_W-1:0]   lrun_r;
  logic [IDX_W-1:0]   lstart_r;
  logic [SUM_W-1:0]   lbest_r;
  logic [IDX_W-1:0]   lbs_r;
  logic [IDX_W-1:0]   lbe_r;

  logic [SUM_W-1:0]   v_ext;
  logic [IDX_W-1:0]   pos_next;
  logic [SUM_W-1:0]   total_new;
  logic               peak_upd;
  logic               trough_upd;
  logic [VALUE_W-1:0] peak_val_new;
  logic [IDX_W-1:0]   peak_idx_new;
  logic [VALUE_W-1:0] trough_val_new;
  logic [IDX_W-1:0]   trough_idx_new;
  logic [SUM_W-1:0]   hsum;
  logic [SUM_W-1:0]   hrun_new;
  logic [IDX_W-1:0]   hstart_new;
  logic               hupd;
  logic [SUM_W-1:0]   hbest_new;
  logic [IDX_W-1:0]   hbs_new;
  logic [IDX_W-1:0]   hbe_new;
  logic [SUM_W-1:0]   lsum;
  logic [SUM_W-1:0]   lrun_new;
  logic [IDX_W-1:0]   lstart_new;
  logic               lupd;
  logic [SUM_W-1:0]   lbest_new;
  logic [IDX_W-1:0]   lbs_new;
  logic [IDX_W-1:0]   lbe_new;

  // A last word waits here until the snapshot stage is free.
  assign s0_go       = s0_v_r && (!last_r || ld_s1);
  assign in_ch.ready = !s0_v_r || s0_go;
  assign snap_v      = s0_v_r && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      value_r <= in_ch.value;
      last_r  <= in_ch.last;
    end
  end

  always_comb begin
    v_ext    = {{(SUM_W-VALUE_W){value_r[VALUE_W-1]}}, value_r};
    pos_next = (pos_r == IDX_W'(MAX_LENGTH - 1)) ? '0 : pos_r + 1'b1;

    total_new  = total_r + v_ext;
    peak_upd   = !loaded_r || ($signed(value_r) > $signed(peak_val_r));
    trough_upd = !loaded_r || ($signed(value_r) < $signed(trough_val_r));
    peak_val_new   = peak_upd ? value_r : peak_val_r;
    peak_idx_new   = peak_upd ? pos_r : peak_idx_r;
    trough_val_new = trough_upd ? value_r : trough_val_r;
    trough_idx_new = trough_upd ? pos_r : trough_idx_r;

    // Max run: drop it once it goes negative.
    hsum = hrun_r + v_ext;
    if (hsum[SUM_W-1]) begin
      hrun_new   = '0;
      hstart_new = pos_next;
    end else begin
      hrun_new   = hsum;
      hstart_new = hstart_r;
    end
    hupd      = $signed(hrun_new) > $signed(hbest_r);
    hbest_new = hupd ? hrun_new : hbest_r;
    hbs_new   = hupd ? hstart_new : hbs_r;
    hbe_new   = hupd ? pos_r : hbe_r;

    // Min run: drop it once it goes positive.
    lsum = lrun_r + v_ext;
    if (!lsum[SUM_W-1] && (lsum != '0)) begin
      lrun_new   = '0;
      lstart_new = pos_next;
    end else begin
      lrun_new   = lsum;
      lstart_new = lstart_r;
    end
    lupd      = $signed(lrun_new) < $signed(lbest_r);
    lbest_new = lupd ? lrun_new : lbest_r;
    lbs_new   = lupd ? lstart_new : lbs_r;
    lbe_new   = lupd ? pos_r : lbe_r;

    snap.total      = total_new;
    snap.peak_val   = peak_val_new;
    snap.peak_idx   = peak_idx_new;
    snap.trough_val = trough_val_new;
    snap.trough_idx = trough_idx_new;
    snap.hbest      = hbest_new;
    snap.hstart     = hbs_new;
    snap.hend       = hbe_new;
    snap.lbest      = lbest_new;
    snap.lstart     = lbs_new;
    snap.lend       = lbe_new;
    snap.len        = {1'b0, pos_r} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s0_go && last_r)) begin
      loaded_r     <= 1'b0;
      pos_r        <= '0;
      total_r      <= '0;
      peak_val_r   <= '0;
      peak_idx_r   <= '0;
      trough_val_r <= '0;
      trough_idx_r <= '0;
      hrun_r       <= '0;
      hstart_r     <= '0;
      hbest_r      <= '0;
      hbs_r        <= '0;
      hbe_r        <= '0;
      lrun_r       <= '0;
      lstart_r     <= '0;
      lbest_r      <= '0;
      lbs_r        <= '0;
      lbe_r        <= '0;
    end else if (s0_go) begin
      loaded_r     <= 1'b1;
      pos_r        <= pos_next;
      total_r      <= total_new;
      peak_val_r   <= peak_val_new;
      peak_idx_r   <= peak_idx_new;
      trough_val_r <= trough_val_new;
      trough_idx_r <= trough_idx_new;
      hrun_r       <= hrun_new;
      hstart_r     <= hstart_new;
      hbest_r      <= hbest_new;
      hbs_r        <= hbs_new;
      hbe_r        <= hbe_new;
      lrun_r       <= lrun_new;
      lstart_r     <= lstart_new;
      lbest_r      <= lbest_new;
      lbs_r        <= lbs_new;
      lbe_r        <= lbe_new;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s0_go && last_r |=> !loaded_r && (pos_r == '0) && (total_r == '0))
    else $error("accumulators not cleared after last word");

  a_hbest_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !hbest_r[SUM_W-1])
    else $error("best max run went negative");

  a_lbest_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    hbest_r[SUM_W-1] || (lbest_r[SUM_W-1] || (lbest_r == '0)))
    else $error("best min run went positive");

endmodule

>>> sv/cmsb_sel.sv
module cmsb_sel (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            snap_v,
  input  cmsb_pkg::snap_t snap,
  output logic            ld_s1,
  input  logic            ld_s3,
  output logic            job_v,
  output cmsb_pkg::job_t  job
);
  import cmsb_pkg::*;

  logic             s1_v_r;
  snap_t            s1_r;
  logic             s2_v_r;
  job_t             s2_r;
  logic             ld_s2;

  logic [SUM_W-1:0] low_sum;
  logic [IDX_W-1:0] low_s;
  logic [IDX_W-1:0] low_e;
  logic [SUM_W-1:0] wrap_sum;
  logic             lin_wins;
  job_t             job_nxt;

  assign ld_s2 = !s2_v_r || ld_s3;
  assign ld_s1 = !s1_v_r || ld_s2;
  assign job_v = s2_v_r;
  assign job   = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (ld_s1) begin
        s1_v_r <= snap_v;
      end
      if (ld_s2) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_comb begin
    // With no negative element the min run is the smallest element alone.
    if (!s1_r.trough_val[VALUE_W-1]) begin
      low_sum = {{(SUM_W-VALUE_W){1'b0}}, s1_r.trough_val};
      low_s   = s1_r.trough_idx;
      low_e   = s1_r.trough_idx;
    end else begin
      low_sum = s1_r.lbest;
      low_s   = s1_r.lstart;
      low_e   = s1_r.lend;
    end
    wrap_sum = s1_r.total - low_sum;
    lin_wins = $signed(s1_r.hbest) >= $signed(wrap_sum);

    // An all-ones length leaves the index untouched in the modulo stages.
    if ($signed(s1_r.peak_val) <= 0) begin
      job_nxt.ds  = {1'b0, s1_r.peak_idx};
      job_nxt.de  = {1'b0, s1_r.peak_idx};
      job_nxt.len = '1;
    end else if (lin_wins) begin
      job_nxt.ds  = {1'b0, s1_r.hstart};
      job_nxt.de  = {1'b0, s1_r.hend};
      job_nxt.len = '1;
    end else begin
      job_nxt.ds  = {1'b0, low_e} + 1'b1;
      job_nxt.de  = {1'b0, low_s} + s1_r.len - 1'b1;
      job_nxt.len = s1_r.len;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_s1) begin
      s1_r <= snap;
    end
    if (ld_s2) begin
      s2_r <= job_nxt;
    end
  end

endmodule

>>> sv/cmsb_mod.sv
module cmsb_mod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_v,
  input  cmsb_pkg::job_t job,
  output logic           ld_s3,
  cmsb_out_if.source     out_ch
);
  import cmsb_pkg::*;

  logic             s3_v_r;
  job_t             s3_r;
  logic             out_v_r;
  logic [IDX_W-1:0] s_r;
  logic [IDX_W-1:0] e_r;
  logic             ld_out;
  job_t             s3_nxt;
  logic [LEN_W-1:0] s_nxt;
  logic [LEN_W-1:0] e_nxt;

  assign ld_out = !out_v_r || out_ch.ready;
  assign ld_s3  = !s3_v_r || ld_out;

  assign out_ch.valid       = out_v_r;
  assign out_ch.start_index = s_r;
  assign out_ch.end_index   = e_r;

  // Upper reduction steps.
  always_comb begin
    s3_nxt = job;
    for (int k = LEN_W - 1; k >= MOD_SPLIT; k--) begin
      s3_nxt.ds = mod_step(s3_nxt.ds, job.len, k);
      s3_nxt.de = mod_step(s3_nxt.de, job.len, k);
    end
  end

  // Lower reduction steps.
  always_comb begin
    s_nxt = s3_r.ds;
    e_nxt = s3_r.de;
    for (int k = MOD_SPLIT - 1; k >= 0; k--) begin
      s_nxt = mod_step(s_nxt, s3_r.len, k);
      e_nxt = mod_step(e_nxt, s3_r.len, k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld_s3) begin
        s3_v_r <= job_v;
      end
      if (ld_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_s3) begin
      s3_r <= s3_nxt;
    end
    if (ld_out) begin
      s_r <= s_nxt[IDX_W-1:0];
      e_r <= e_nxt[IDX_W-1:0];
    end
  end

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !ld_out |=> s3_v_r && $stable(s3_r))
    else $error("modulo stage lost its word under stall");

endmodule
